>>> rtl/hdal_pkg.sv
// hdal_pkg: shared widths, register codes, side-band word type and the
// CORDIC arctangent table for the heading align steering block.
// No dependencies.
package hdal_pkg;

	localparam int ANG_W            = 16;
	localparam int RATE_W           = 16;
	localparam int LIM_W            = 15;
	localparam int Z_W              = 32;
	localparam int XY_W             = 20;
	localparam int CFG_IDX_W        = 2;
	localparam int CFG_DATA_W       = 16;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int CORDIC_STEPS_MAX = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ROT_ACC    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ARRIVED_RADIUS = 2'd1;

	localparam logic [LIM_W-1:0] MAX_ROT_ACC_RST    = 15'd256;
	localparam logic [ANG_W-1:0] ARRIVED_RADIUS_RST = 16'd3277;

	localparam logic [Z_W-1:0] Z_HALF_TURN = 32'h8000_0000;
	localparam logic [Z_W-1:0] Z_ROUND     = 32'h0000_8000;

	typedef struct packed {
		logic                     vld;
		logic                     zero;
		logic [ANG_W-1:0]         facing;
		logic signed [RATE_W-1:0] rot_vel;
	} hdal_side_t;

	// atan(2^-i) in units of 2^32 per full turn
	function automatic logic [Z_W-1:0] atan_at(input int i);
		logic [Z_W-1:0] a;
		case (i)
			0:       a = 32'h2000_0000;
			1:       a = 32'h12E4_051E;
			2:       a = 32'h09FB_385B;
			3:       a = 32'h0511_11D4;
			4:       a = 32'h028B_0D43;
			5:       a = 32'h0145_D7E1;
			6:       a = 32'h00A2_F61E;
			7:       a = 32'h0051_7C55;
			8:       a = 32'h0028_BE53;
			9:       a = 32'h0014_5F2F;
			10:      a = 32'h000A_2F98;
			11:      a = 32'h0005_17CC;
			12:      a = 32'h0002_8BE6;
			13:      a = 32'h0001_45F3;
			14:      a = 32'h0000_A2FA;
			15:      a = 32'h0000_517D;
			16:      a = 32'h0000_28BE;
			17:      a = 32'h0000_145F;
			18:      a = 32'h0000_0A30;
			19:      a = 32'h0000_0518;
			20:      a = 32'h0000_028C;
			21:      a = 32'h0000_0146;
			22:      a = 32'h0000_00A3;
			23:      a = 32'h0000_0051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

>>> rtl/hdal_cell.sv
// hdal_cell: one CORDIC vectoring micro-rotation with its output register.
// Depends on hdal_pkg.
module hdal_cell #(
	parameter int STEP = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic signed [hdal_pkg::XY_W-1:0]    x_in,
	input  logic signed [hdal_pkg::XY_W-1:0]    y_in,
	input  logic [hdal_pkg::Z_W-1:0]            z_in,
	input  hdal_pkg::hdal_side_t                side_in,
	output logic signed [hdal_pkg::XY_W-1:0]    x_out,
	output logic signed [hdal_pkg::XY_W-1:0]    y_out,
	output logic [hdal_pkg::Z_W-1:0]            z_out,
	output hdal_pkg::hdal_side_t                side_out
);
	import hdal_pkg::*;

	localparam logic [Z_W-1:0] ATAN = atan_at(STEP);

	logic signed [XY_W-1:0] dx, dy, x_nx, y_nx;
	logic [Z_W-1:0]         z_nx;
	logic                   vld_q;
	hdal_side_t             side_q;

	always_comb begin
		dx = y_in >>> STEP;
		dy = x_in >>> STEP;
		if (y_in > 0) begin
			x_nx = x_in + dx;
			y_nx = y_in - dy;
			z_nx = z_in + ATAN;
		end else begin
			x_nx = x_in - dx;
			y_nx = y_in + dy;
			z_nx = z_in - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= side_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_out  <= x_nx;
			y_out  <= y_nx;
			z_out  <= z_nx;
			side_q <= side_in;
		end
	end

	always_comb begin
		side_out     = side_q;
		side_out.vld = vld_q;
	end

endmodule

>>> rtl/hdal_post.sv
// hdal_post: heading error, target turn rate and saturated acceleration,
// three register stages ending in the output register. Depends on hdal_pkg.
module hdal_post (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic [hdal_pkg::Z_W-1:0]            z_in,
	input  hdal_pkg::hdal_side_t                side_in,
	input  logic [hdal_pkg::LIM_W-1:0]          max_rot_acc,
	input  logic [hdal_pkg::ANG_W-1:0]          arrived_radius,
	output logic                                vld_out,
	output logic signed [hdal_pkg::RATE_W-1:0]  acc_out
);
	import hdal_pkg::*;

	localparam int PROD_W = LIM_W + ANG_W;
	localparam int ACC_W  = RATE_W + 4;

	// stage 1 inputs
	logic [Z_W-1:0]   z_rnd;
	logic [ANG_W-1:0] tgt, err, mag;
	logic             pos, neg;

	// stage 1
	logic                     vld_s1, pos_s1, neg_s1, arr_s1;
	logic [ANG_W-1:0]         mag_s1;
	logic signed [RATE_W-1:0] rv_s1;

	// stage 2
	logic                     vld_s2, pos_s2, neg_s2, arr_s2;
	logic [PROD_W-1:0]        prod_s2;
	logic signed [RATE_W-1:0] rv_s2;

	// stage 3 logic
	logic signed [RATE_W:0]  rate_abs, rate;
	logic signed [ACC_W-1:0] acc, lim_p, lim_n, acc_sat;

	logic                     vld_q;
	logic signed [RATE_W-1:0] acc_q;

	always_comb begin
		z_rnd = z_in + Z_ROUND;
		tgt   = side_in.zero ? '0 : z_rnd[Z_W-1 -: ANG_W];
		err   = tgt - side_in.facing;
		pos   = (err != '0) && (err <= 16'h8000);
		neg   = err > 16'h8000;
		mag   = neg ? (~err + 16'd1) : err;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (en) begin
			vld_s1 <= side_in.vld;
			vld_s2 <= vld_s1;
			vld_q  <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s1  <= pos;
			neg_s1  <= neg;
			arr_s1  <= mag < arrived_radius;
			mag_s1  <= mag;
			rv_s1   <= side_in.rot_vel;
			pos_s2  <= pos_s1;
			neg_s2  <= neg_s1;
			arr_s2  <= arr_s1;
			rv_s2   <= rv_s1;
			prod_s2 <= PROD_W'(max_rot_acc) * PROD_W'(mag_s1);
			acc_q   <= acc_sat[RATE_W-1:0];
		end
	end

	always_comb begin
		rate_abs = arr_s2 ? (RATE_W+1)'(rv_s2)
		                  : $signed({1'b0, prod_s2[PROD_W-1 -: RATE_W]});
		if (pos_s2) begin
			rate = rate_abs;
		end else if (neg_s2) begin
			rate = -rate_abs;
		end else begin
			rate = '0;
		end
		acc   = (ACC_W'(rate) - ACC_W'(rv_s2)) <<< 1;
		lim_p = $signed({{(ACC_W-LIM_W){1'b0}}, max_rot_acc});
		lim_n = -lim_p;
		if (acc > lim_p) begin
			acc_sat = lim_p;
		end else if (acc < lim_n) begin
			acc_sat = lim_n;
		end else begin
			acc_sat = acc;
		end
	end

	assign vld_out = vld_q;
	assign acc_out = acc_q;

endmodule

>>> rtl/heading_align_steering.sv
// heading_align_steering: top level; input register, CORDIC cell chain,
// post stages and configuration registers. Depends on hdal_pkg, hdal_cell, hdal_post.
//
// channel  signals                                  direction
// input    in_valid in_stall vel_x vel_y facing rot_vel  in (in_stall out)
// output   out_valid out_stall rot_acc              out (out_stall in)
// config   cfg_valid cfg_ready cfg_index cfg_data   in (cfg_ready out)
//
// One word per cycle while the output word is not stalled; registers in order:
// input register, one cell per micro-rotation, two post stages, output register.
// The whole pipeline holds while the output word is stalled.
// Reset clears valid bits and loads the register reset values.
module heading_align_steering #(
	parameter int CORDIC_STEPS = hdal_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [hdal_pkg::RATE_W-1:0]    vel_x,
	input  logic signed [hdal_pkg::RATE_W-1:0]    vel_y,
	input  logic [hdal_pkg::ANG_W-1:0]            facing,
	input  logic signed [hdal_pkg::RATE_W-1:0]    rot_vel,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [hdal_pkg::RATE_W-1:0]    rot_acc,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hdal_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hdal_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import hdal_pkg::*;

	logic                   en;
	logic [LIM_W-1:0]       max_rot_acc_q;
	logic [ANG_W-1:0]       arrived_radius_q;
	logic signed [XY_W-1:0] x0, y0;
	logic [Z_W-1:0]         z0;
	logic                   in_vld_q;
	hdal_side_t             side0;

	logic signed [XY_W-1:0] x_c [0:CORDIC_STEPS];
	logic signed [XY_W-1:0] y_c [0:CORDIC_STEPS];
	logic [Z_W-1:0]         z_c [0:CORDIC_STEPS];
	hdal_side_t             s_c [0:CORDIC_STEPS];

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rot_acc_q    <= MAX_ROT_ACC_RST;
			arrived_radius_q <= ARRIVED_RADIUS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_ROT_ACC:    max_rot_acc_q    <= cfg_data[LIM_W-1:0];
				REG_ARRIVED_RADIUS: arrived_radius_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// start vector (vel_y, -vel_x), turned by pi into the right half plane
	always_comb begin
		x0 = XY_W'(vel_y);
		y0 = -XY_W'(vel_x);
		z0 = '0;
		if (x0 < 0) begin
			x0 = -x0;
			y0 = -y0;
			z0 = Z_HALF_TURN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_q <= 1'b0;
		end else if (en) begin
			in_vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_c[0]            <= x0;
			y_c[0]            <= y0;
			z_c[0]            <= z0;
			side0.vld         <= in_valid;
			side0.zero        <= (vel_x == '0) && (vel_y == '0);
			side0.facing      <= facing;
			side0.rot_vel     <= rot_vel;
		end
	end

	always_comb begin
		s_c[0]     = side0;
		s_c[0].vld = in_vld_q;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
		hdal_cell #(.STEP(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.x_in    (x_c[i]),
			.y_in    (y_c[i]),
			.z_in    (z_c[i]),
			.side_in (s_c[i]),
			.x_out   (x_c[i+1]),
			.y_out   (y_c[i+1]),
			.z_out   (z_c[i+1]),
			.side_out(s_c[i+1])
		);
	end

	hdal_post u_post (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.z_in          (z_c[CORDIC_STEPS]),
		.side_in       (s_c[CORDIC_STEPS]),
		.max_rot_acc   (max_rot_acc_q),
		.arrived_radius(arrived_radius_q),
		.vld_out       (out_valid),
		.acc_out       (rot_acc)
	);

endmodule
